>>> sv/alpc_pkg.sv
package alpc_pkg;

  // Function codes of an input transaction
  localparam logic [1:0] FN_REQUEST = 2'd0;
  localparam logic [1:0] FN_SWEEP   = 2'd1;
  localparam logic [1:0] FN_CLEAR   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_UNLOADED = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_SWEPT    = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_ENTRIES   = 2'd0;
  localparam logic [1:0] CFG_MIN_ENTRIES   = 2'd1;
  localparam logic [1:0] CFG_EXPIRY_AGE    = 2'd2;
  localparam logic [1:0] CFG_EVICT_MIN_AGE = 2'd3;

  // Configuration reset values
  localparam logic [4:0]  MAX_ENTRIES_RST   = 5'd16;
  localparam logic [4:0]  MIN_ENTRIES_RST   = 5'd0;
  localparam logic [31:0] EXPIRY_AGE_RST    = 32'd5000;
  localparam logic [31:0] EVICT_MIN_AGE_RST = 32'd1000;

  // Selection rule applied by the table scan
  typedef enum logic {
    SCAN_OLDEST,
    SCAN_MINKEY
  } scan_mode_t;

  typedef struct packed {
    logic       start;
    scan_mode_t mode;
  } scan_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic best_have;
  } scan_flags_t;

  typedef struct packed {
    logic stb;
    logic elig;
    logic expired;
  } scan_elem_t;

endpackage

>>> sv/alpc_ram.sv
module alpc_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/alpc_scan.sv
module alpc_scan #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned TIME_BITS = 32,
  localparam int unsigned IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned KEY_W   = (KEY_BITS < 32) ? KEY_BITS : 32,
  localparam int unsigned STAMP_W = (TIME_BITS < 32) ? TIME_BITS : 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  alpc_pkg::scan_cmd_t      cmd,
  input  logic [CAPACITY-1:0]      elig,
  input  logic [KEY_W-1:0]         req_key,
  input  logic [31:0]              now,
  input  logic [31:0]              expiry_age,
  output logic                     rd_en,
  output logic [IDX_W-1:0]         rd_addr,
  input  logic [KEY_W+STAMP_W-1:0] rd_data,
  output alpc_pkg::scan_elem_t     elem,
  output logic [IDX_W-1:0]         elem_idx,
  output alpc_pkg::scan_flags_t    flags,
  output logic [IDX_W-1:0]         hit_slot,
  output logic [IDX_W-1:0]         best_slot,
  output logic [TIME_BITS-1:0]     best_age
);

  import alpc_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic                 running;
  logic [IDX_W-1:0]     cnt;
  scan_mode_t           mode;
  logic                 p1_vld;
  logic                 p1_last;
  logic [IDX_W-1:0]     p1_idx;
  logic [KEY_W-1:0]     p1_key;
  logic [STAMP_W-1:0]   p1_stamp;
  logic [TIME_BITS-1:0] p1_age;
  logic                 b_vld;
  logic                 b_last;
  logic                 b_elig;
  logic                 b_match;
  logic                 b_exp;
  logic [IDX_W-1:0]     b_idx;
  logic [KEY_W-1:0]     b_key;
  logic [TIME_BITS-1:0] b_age;
  logic [KEY_W-1:0]     best_key;
  logic                 better;

  // Address sweep over the whole table, one read a cycle
  assign rd_en   = running;
  assign rd_addr = cnt;

  // Read data split and wrapping age
  assign p1_key   = rd_data[KEY_W+STAMP_W-1:STAMP_W];
  assign p1_stamp = rd_data[STAMP_W-1:0];
  assign p1_age   = TIME_BITS'(now) - TIME_BITS'(p1_stamp);

  // Candidate against current best
  always_comb begin
    if (!flags.best_have) begin
      better = 1'b1;
    end else if (mode == SCAN_MINKEY) begin
      better = b_key < best_key;
    end else begin
      better = (b_age > best_age) || ((b_age == best_age) && (b_key < best_key));
    end
  end

  assign elem.stb     = b_vld;
  assign elem.elig    = b_elig;
  assign elem.expired = b_exp;
  assign elem_idx     = b_idx;

  // Control: sweep counter, pipeline valids, result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      p1_vld  <= 1'b0;
      p1_last <= 1'b0;
      b_vld   <= 1'b0;
      b_last  <= 1'b0;
      flags   <= '0;
    end else begin
      if (cmd.start) begin
        running <= 1'b1;
      end else if (running && (cnt == LAST_IDX)) begin
        running <= 1'b0;
      end
      p1_vld     <= running;
      p1_last    <= running && (cnt == LAST_IDX);
      b_vld      <= p1_vld;
      b_last     <= p1_last;
      flags.done <= b_vld && b_last;
      if (cmd.start) begin
        flags.hit       <= 1'b0;
        flags.best_have <= 1'b0;
      end else if (b_vld && b_elig) begin
        if (b_match) begin
          flags.hit <= 1'b1;
        end
        if (better) begin
          flags.best_have <= 1'b1;
        end
      end
    end
  end

  // Datapath: address, pipeline payload, best tracking
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt  <= '0;
      mode <= cmd.mode;
    end else if (running) begin
      cnt <= cnt + IDX_W'(1);
    end
    p1_idx  <= cnt;
    b_idx   <= p1_idx;
    b_elig  <= elig[p1_idx];
    b_key   <= p1_key;
    b_age   <= p1_age;
    b_match <= p1_key == req_key;
    b_exp   <= CMP_W'(p1_age) > CMP_W'(expiry_age);
    if (!cmd.start && b_vld && b_elig) begin
      if (b_match && !flags.hit) begin
        hit_slot <= b_idx;
      end
      if (better) begin
        best_slot <= b_idx;
        best_key  <= b_key;
        best_age  <= b_age;
      end
    end
  end

endmodule

>>> sv/aged_lru_preload_cache_unit.sv
// Keyed cache table with least-recently-used eviction and age expiry. Each
// input transaction (request, sweep or clear) gives exactly one result
// transaction. Keys and last-use stamps sit in one synchronous memory with a
// write port and a registered read port. Every lookup, oldest-entry search and
// sweep walks that memory one entry a cycle. An insert takes one more pass per
// eviction, and a sweep one more pass per removal when min_entries limits how
// many expired entries may go; a clear, an unloaded request or the spare code
// needs no pass. One item is worked on at a time; a finished result waits in
// the output register while the next request is taken in.
module aged_lru_preload_cache_unit #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  func,
  input  logic [31:0] cell_key,
  input  logic        cell_loaded,
  input  logic [31:0] now,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic [4:0]  entries_in_use,
  output logic [4:0]  removed_count
);

  import alpc_pkg::*;

  localparam int unsigned IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned KEY_W   = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned STAMP_W = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int unsigned DATA_W  = KEY_W + STAMP_W;
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned LIM_W   = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned CMP_W   = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EVICT,
    S_EVSCAN,
    S_SWEEP,
    S_TRIM,
    S_SELECT,
    S_DONE
  } state_t;

  state_t               state;
  logic [4:0]           max_entries;
  logic [4:0]           min_entries;
  logic [31:0]          expiry_age;
  logic [31:0]          evict_min_age;
  logic [CAPACITY-1:0]  valid;
  logic [CAPACITY-1:0]  expired;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     removed;
  logic [CNT_W-1:0]     exp_cnt;
  logic [CNT_W-1:0]     remain;
  logic [IDX_W-1:0]     free_slot;
  logic                 free_have;
  logic [KEY_W-1:0]     op_key;
  logic [31:0]          op_now;
  logic [2:0]           res_status;
  logic [IDX_W-1:0]     res_slot;

  logic                 accept;
  logic [LIM_W-1:0]     limit;
  logic                 need_evict;
  logic                 old_enough;
  logic                 below_min;
  logic [LIM_W:0]       avail;
  logic                 all_fit;

  scan_cmd_t            scan_cmd;
  scan_elem_t           elem;
  scan_flags_t          flags;
  logic [CAPACITY-1:0]  elig;
  logic [IDX_W-1:0]     elem_idx;
  logic [IDX_W-1:0]     hit_slot;
  logic [IDX_W-1:0]     best_slot;
  logic [TIME_BITS-1:0] best_age;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // Effective table limit; zero or oversize means full capacity
  always_comb begin
    if ((max_entries == 5'd0) || (LIM_W'(max_entries) > LIM_W'(CAPACITY))) begin
      limit = LIM_W'(CAPACITY);
    end else begin
      limit = LIM_W'(max_entries);
    end
  end

  assign need_evict = (LIM_W'(count) >= limit) && (count != '0);
  assign old_enough = CMP_W'(best_age) > CMP_W'(evict_min_age);

  // Sweep trimming: how many expired entries may go; removal stops one below min
  assign below_min = LIM_W'(count) < LIM_W'(min_entries);
  assign avail     = (LIM_W + 1)'(count) + (LIM_W + 1)'(1) - (LIM_W + 1)'(min_entries);
  assign all_fit   = (LIM_W + 1)'(exp_cnt) <= avail;

  // Scan launch
  always_comb begin
    scan_cmd.start = 1'b0;
    scan_cmd.mode  = SCAN_OLDEST;
    unique case (state)
      S_IDLE: begin
        scan_cmd.start = accept && (((func == FN_REQUEST) && cell_loaded) ||
                                    (func == FN_SWEEP));
      end
      S_EVICT: begin
        scan_cmd.start = need_evict && old_enough;
      end
      S_TRIM: begin
        scan_cmd.start = !below_min && !all_fit;
        scan_cmd.mode  = SCAN_MINKEY;
      end
      S_SELECT: begin
        scan_cmd.start = flags.done && (remain != CNT_W'(1));
        scan_cmd.mode  = SCAN_MINKEY;
      end
      default: begin
        scan_cmd.start = 1'b0;
      end
    endcase
  end

  assign elig = (state == S_SELECT) ? (valid & expired) : valid;

  // Memory writes happen only between scans, so no read/write overlap arises
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_slot;
    if ((state == S_LOOKUP) && flags.done && flags.hit) begin
      ram_we = 1'b1;
    end
    if ((state == S_EVICT) && !need_evict) begin
      ram_we    = 1'b1;
      ram_waddr = free_slot;
    end
  end

  assign ram_wdata = {op_key, STAMP_W'(op_now)};

  alpc_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  alpc_scan #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cmd        (scan_cmd),
    .elig       (elig),
    .req_key    (op_key),
    .now        (op_now),
    .expiry_age (expiry_age),
    .rd_en      (ram_re),
    .rd_addr    (ram_raddr),
    .rd_data    (ram_rdata),
    .elem       (elem),
    .elem_idx   (elem_idx),
    .flags      (flags),
    .hit_slot   (hit_slot),
    .best_slot  (best_slot),
    .best_age   (best_age)
  );

  // Sequencer, table bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rsp_valid     <= 1'b0;
      valid         <= '0;
      count         <= '0;
      free_have     <= 1'b0;
      max_entries   <= MAX_ENTRIES_RST;
      min_entries   <= MIN_ENTRIES_RST;
      expiry_age    <= EXPIRY_AGE_RST;
      evict_min_age <= EVICT_MIN_AGE_RST;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_MAX_ENTRIES:   max_entries   <= cfg_data[4:0];
          CFG_MIN_ENTRIES:   min_entries   <= cfg_data[4:0];
          CFG_EXPIRY_AGE:    expiry_age    <= cfg_data;
          CFG_EVICT_MIN_AGE: evict_min_age <= cfg_data;
        endcase
      end

      // Result taken; a waiting result reloads the register in S_DONE instead
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_key    <= KEY_W'(cell_key);
            op_now    <= now;
            res_slot  <= '0;
            free_have <= 1'b0;
            exp_cnt   <= '0;
            if ((func == FN_REQUEST) && cell_loaded) begin
              removed <= '0;
              state   <= S_LOOKUP;
            end else if (func == FN_SWEEP) begin
              removed <= '0;
              state   <= S_SWEEP;
            end else if (func == FN_CLEAR) begin
              removed    <= count;
              valid      <= '0;
              count      <= '0;
              res_status <= ST_CLEARED;
              state      <= S_DONE;
            end else begin
              removed    <= '0;
              res_status <= ST_UNLOADED;
              state      <= S_DONE;
            end
          end
        end

        // Lookup pass: also notes the lowest free slot
        S_LOOKUP: begin
          if (elem.stb && !elem.elig && !free_have) begin
            free_have <= 1'b1;
            free_slot <= elem_idx;
          end
          if (flags.done) begin
            if (flags.hit) begin
              res_status <= ST_HIT;
              res_slot   <= hit_slot;
              state      <= S_DONE;
            end else begin
              state <= S_EVICT;
            end
          end
        end

        // Evict the oldest entry, refuse, or insert
        S_EVICT: begin
          if (need_evict) begin
            if (old_enough) begin
              valid[best_slot] <= 1'b0;
              count            <= count - CNT_W'(1);
              removed          <= removed + CNT_W'(1);
              if (!free_have || (best_slot < free_slot)) begin
                free_have <= 1'b1;
                free_slot <= best_slot;
              end
              state <= S_EVSCAN;
            end else begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end
          end else begin
            valid[free_slot] <= 1'b1;
            count            <= count + CNT_W'(1);
            res_status       <= ST_INSERTED;
            res_slot         <= free_slot;
            state            <= S_DONE;
          end
        end

        S_EVSCAN: begin
          if (flags.done) begin
            state <= S_EVICT;
          end
        end

        // Sweep pass: mark expired entries
        S_SWEEP: begin
          if (elem.stb) begin
            expired[elem_idx] <= elem.elig && elem.expired;
            if (elem.elig && elem.expired) begin
              exp_cnt <= exp_cnt + CNT_W'(1);
            end
          end
          if (flags.done) begin
            state <= S_TRIM;
          end
        end

        // Drop all marked entries at once when the minimum allows it
        S_TRIM: begin
          res_status <= ST_SWEPT;
          if (below_min) begin
            state <= S_DONE;
          end else if (all_fit) begin
            valid   <= valid & ~expired;
            count   <= count - exp_cnt;
            removed <= exp_cnt;
            state   <= S_DONE;
          end else begin
            remain <= CNT_W'(avail);
            state  <= S_SELECT;
          end
        end

        // Otherwise drop marked entries smallest key first, one per pass
        S_SELECT: begin
          if (flags.done) begin
            valid[best_slot]   <= 1'b0;
            expired[best_slot] <= 1'b0;
            count              <= count - CNT_W'(1);
            removed            <= removed + CNT_W'(1);
            if (remain == CNT_W'(1)) begin
              state <= S_DONE;
            end else begin
              remain <= remain - CNT_W'(1);
            end
          end
        end

        // Hand the result transaction to the output register
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            status         <= res_status;
            slot           <= 4'(res_slot);
            entries_in_use <= 5'(count);
            removed_count  <= 5'(removed);
            state          <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> sv/alpc_checker.sv
module alpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [2:0] status,
  input logic [3:0] slot,
  input logic [4:0] entries_in_use,
  input logic [4:0] removed_count
);

  import alpc_pkg::*;

  // A stalled result transaction stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(removed_count))
    else $error("stalled result changed");

  // Slot is only reported for hits and inserts
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_HIT) && (status != ST_INSERTED) |-> slot == 4'd0)
    else $error("slot set for a status without a slot");

  // A clear leaves the table empty
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_CLEARED) |-> entries_in_use == 5'd0)
    else $error("clear left entries behind");

  // Hits and refused unloaded requests remove nothing
  a_no_removal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((status == ST_HIT) || (status == ST_UNLOADED)) |-> removed_count == 5'd0)
    else $error("removal reported without eviction");

  // An accepted request keeps the input side busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input taken again straight after a transaction");

endmodule

bind aged_lru_preload_cache_unit alpc_checker u_alpc_checker (.*);

>>> tb/aged_lru_preload_cache_unit_tb.sv
`timescale 1ns / 100ps

module aged_lru_preload_cache_unit_tb;
  import alpc_pkg::*;

  localparam int DEPTH     = 16;
  localparam int POOL      = 24;
  localparam int PHASES    = 12;
  localparam int PER_PHASE = 136;
  localparam int IDLE_GAP  = 8;

  // The package has no name for the spare function code
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  fn;
    logic [31:0] key;
    logic        loaded;
    logic [31:0] tick;
  } cache_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [4:0] in_use;
    logic [4:0] removed;
  } cache_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_MAX_ENTRIES;
  logic [31:0] cfg_data = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  func = FN_REQUEST;
  logic [31:0] cell_key = '0;
  logic        cell_loaded = 1'b0;
  logic [31:0] now = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [4:0]  entries_in_use;
  logic [4:0]  removed_count;

  aged_lru_preload_cache_unit uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .func           (func),
    .cell_key       (cell_key),
    .cell_loaded    (cell_loaded),
    .now            (now),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .slot           (slot),
    .entries_in_use (entries_in_use),
    .removed_count  (removed_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the cache contents and its registers
  logic        tbl_valid [DEPTH];
  logic [31:0] tbl_key   [DEPTH];
  logic [31:0] tbl_stamp [DEPTH];
  int          tbl_count = 0;
  logic [4:0]  lim_max   = MAX_ENTRIES_RST;
  logic [4:0]  lim_min   = MIN_ENTRIES_RST;
  logic [31:0] expiry    = EXPIRY_AGE_RST;
  logic [31:0] evict_age = EVICT_MIN_AGE_RST;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_stamp[i] = '0;
    end
  end

  cache_req_t pending_reqs [$];
  cache_rsp_t due_results  [$];
  cache_req_t cur_req = '0;

  int fault_count = 0;
  int checked_count = 0;
  int setting_count = 0;
  int n_request = 0, n_sweep = 0, n_clear = 0, n_other = 0;
  int n_hit = 0, n_insert = 0, n_full = 0, n_dropped = 0;

  // Wrapping age of a slot at the given tick
  function automatic logic [31:0] age_of_slot(int s, logic [31:0] t);
    return t - tbl_stamp[s];
  endfunction

  // Largest age wins; equal ages go to the smaller key
  function automatic int oldest_slot(logic [31:0] t);
    int   best;
    logic have;
    best = 0;
    have = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i] && (!have || age_of_slot(i, t) > age_of_slot(best, t) ||
          (age_of_slot(i, t) == age_of_slot(best, t) && tbl_key[i] < tbl_key[best]))) begin
        best = i;
        have = 1'b1;
      end
    end
    return best;
  endfunction

  // Applies one transaction to the shadow table and returns its result
  function automatic cache_rsp_t predict_cache_op(cache_req_t rq);
    cache_rsp_t rs;
    int         limit, victim, n, k;
    logic       hit, refused, placed;
    int         order [DEPTH];
    rs = '0;
    rs.status = ST_UNLOADED;
    if (rq.fn == FN_REQUEST && rq.loaded) begin
      hit = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (!hit && tbl_valid[i] && tbl_key[i] == rq.key) begin
          tbl_stamp[i] = rq.tick;
          rs.status = ST_HIT;
          rs.slot = 4'(i);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        limit = (lim_max == 5'd0 || lim_max > DEPTH) ? DEPTH : int'(lim_max);
        refused = 1'b0;
        // keep evicting while the table sits at or over its limit
        while (!refused && tbl_count >= limit && tbl_count > 0) begin
          victim = oldest_slot(rq.tick);
          if (age_of_slot(victim, rq.tick) > evict_age) begin
            tbl_valid[victim] = 1'b0;
            tbl_count--;
            rs.removed = rs.removed + 5'd1;
          end else begin
            refused = 1'b1;
          end
        end
        if (refused) begin
          rs.status = ST_FULL;
        end else begin
          placed = 1'b0;
          for (int i = 0; i < DEPTH; i++) begin
            if (!placed && !tbl_valid[i]) begin
              tbl_valid[i] = 1'b1;
              tbl_key[i]   = rq.key;
              tbl_stamp[i] = rq.tick;
              tbl_count++;
              rs.slot = 4'(i);
              placed = 1'b1;
            end
          end
          rs.status = ST_INSERTED;
        end
      end
    end else if (rq.fn == FN_SWEEP) begin
      // visit valid slots in ascending key order
      n = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i]) begin
          k = n;
          while (k > 0 && tbl_key[order[k - 1]] > tbl_key[i]) begin
            order[k] = order[k - 1];
            k--;
          end
          order[k] = i;
          n++;
        end
      end
      for (int j = 0; j < n; j++) begin
        if (tbl_count >= lim_min && age_of_slot(order[j], rq.tick) > expiry) begin
          tbl_valid[order[j]] = 1'b0;
          tbl_count--;
          rs.removed = rs.removed + 5'd1;
        end
      end
      rs.status = ST_SWEPT;
    end else if (rq.fn == FN_CLEAR) begin
      rs.removed = 5'(tbl_count);
      for (int i = 0; i < DEPTH; i++)
        tbl_valid[i] = 1'b0;
      tbl_count = 0;
      rs.status = ST_CLEARED;
    end
    rs.in_use = 5'(tbl_count);
    return rs;
  endfunction

  function automatic void queue_item(logic [1:0] fn, logic [31:0] key, logic loaded,
                                     logic [31:0] t);
    cache_req_t rq;
    rq.fn = fn;
    rq.key = key;
    rq.loaded = loaded;
    rq.tick = t;
    pending_reqs = {pending_reqs, rq};
  endfunction

  // Register write; the shadow copy follows at the same edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_MAX_ENTRIES:   lim_max = val[4:0];
      CFG_MIN_ENTRIES:   lim_min = val[4:0];
      CFG_EXPIRY_AGE:    expiry = val;
      CFG_EVICT_MIN_AGE: evict_age = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] mx, input logic [31:0] mn,
                            input logic [31:0] ex, input logic [31:0] ev);
    write_reg(CFG_MAX_ENTRIES, mx);
    write_reg(CFG_MIN_ENTRIES, mn);
    write_reg(CFG_EXPIRY_AGE, ex);
    write_reg(CFG_EVICT_MIN_AGE, ev);
    setting_count++;
  endtask

  // Wait until every queued transaction is sent and answered
  task automatic settle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || due_results.size() != 0)
      @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  // Request driver: random gap before each transaction, with calm stretches
  int   req_gap = 0;
  logic req_calm = 1'b0;

  always @(posedge clk) begin : req_driver
    cache_rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        want = predict_cache_op(cur_req);
        due_results = {due_results, want};
        case (cur_req.fn)
          FN_REQUEST: n_request++;
          FN_SWEEP:   n_sweep++;
          FN_CLEAR:   n_clear++;
          default:    n_other++;
        endcase
        if (want.status == ST_HIT) n_hit++;
        if (want.status == ST_INSERTED) n_insert++;
        if (want.status == ST_FULL) n_full++;
        n_dropped += int'(want.removed);
        if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
        req_gap = req_calm ? 0 : $urandom_range(0, 6);
      end
      if (!req_valid || !req_stall) begin
        if (req_gap == 0 && pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          req_valid   <= 1'b1;
          func        <= cur_req.fn;
          cell_key    <= cur_req.key;
          cell_loaded <= cur_req.loaded;
          now         <= cur_req.tick;
        end else begin
          req_valid <= 1'b0;
          if (req_gap != 0) req_gap--;
        end
      end
    end
  end

  // Result monitor: stalls each result a random number of cycles
  int   rsp_hold = 0;
  logic rsp_calm = 1'b0;

  always @(posedge clk) begin : rsp_monitor
    cache_rsp_t seen, want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        seen.status  = status;
        seen.slot    = slot;
        seen.in_use  = entries_in_use;
        seen.removed = removed_count;
        checked_count++;
        if (due_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: unexpected result status %0d slot %0d in_use %0d removed %0d",
                     $realtime, seen.status, seen.slot, seen.in_use, seen.removed);
        end else begin
          want = due_results.pop_front();
          if (seen.status !== want.status || seen.slot !== want.slot ||
              seen.in_use !== want.in_use || seen.removed !== want.removed) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"%0t: result %0d expected status %0d slot %0d in_use %0d ",
                        "removed %0d, got status %0d slot %0d in_use %0d removed %0d"},
                       $realtime, checked_count, want.status, want.slot, want.in_use,
                       want.removed, seen.status, seen.slot, seen.in_use, seen.removed);
          end
        end
        if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
        rsp_hold = rsp_calm ? 0 : $urandom_range(0, 6);
      end else if (rsp_valid && rsp_hold != 0) begin
        rsp_hold--;
      end
      rsp_stall <= (rsp_hold != 0);
    end
  end

  // Stimulus: directed checks, then random phases under varied settings
  initial begin : stimulus
    logic [31:0] tick, step, key;
    logic [31:0] key_pool [POOL];
    int          r;
    tick = 32'd1400;
    step = 32'd100;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: operation codes, field extremes, wrapping age
    queue_item(FN_REQUEST, 32'd5, 1'b0, 32'd0);
    queue_item(FN_SWEEP, 32'd0, 1'b0, 32'd0);
    queue_item(FN_REQUEST, 32'd0, 1'b1, 32'd100);
    queue_item(FN_REQUEST, 32'hFFFF_FFFF, 1'b1, 32'd200);
    queue_item(FN_REQUEST, 32'd0, 1'b1, 32'd300);
    queue_item(FN_REQUEST, 32'd0, 1'b0, 32'd400);
    queue_item(FN_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    queue_item(FN_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'd500);
    queue_item(FN_REQUEST, 32'h1234_5678, 1'b1, 32'hFFFF_FF00);
    queue_item(FN_SWEEP, 32'd0, 1'b1, 32'h0000_1000);
    queue_item(FN_SWEEP, 32'd0, 1'b0, 32'h0000_2000);
    settle();

    // sweep down to one below the minimum count
    set_config(32'd16, 32'd3, 32'd100, 32'd50);
    queue_item(FN_REQUEST, 32'd10, 1'b1, 32'd1000);
    queue_item(FN_REQUEST, 32'd20, 1'b1, 32'd1000);
    queue_item(FN_REQUEST, 32'd5, 1'b1, 32'd1100);
    queue_item(FN_REQUEST, 32'd30, 1'b1, 32'd1200);
    queue_item(FN_REQUEST, 32'd20, 1'b1, 32'd1250);
    queue_item(FN_SWEEP, 32'd0, 1'b1, 32'd1300);
    queue_item(FN_REQUEST, 32'd10, 1'b1, 32'd1300);
    queue_item(FN_REQUEST, 32'd5, 1'b1, 32'd1300);
    settle();

    // limit lowered under a fuller table, refusal after evictions, equal ages
    set_config(32'd2, 32'd0, 32'd0, 32'd50);
    queue_item(FN_REQUEST, 32'd40, 1'b1, 32'd1310);
    queue_item(FN_REQUEST, 32'd50, 1'b1, 32'd1400);
    queue_item(FN_SWEEP, 32'd0, 1'b0, 32'd1400);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:  begin set_config(32'd16, 32'd0, 32'd5000, 32'd1000);   step = 32'd400;  end
        1:  begin set_config(32'd4, 32'd0, 32'd300, 32'd100);      step = 32'd40;   end
        2:  begin set_config(32'd1, 32'd0, 32'd200, 32'd50);       step = 32'd30;   end
        3:  begin set_config(32'd0, 32'd2, 32'd1000, 32'd0);       step = 32'd120;  end
        4:  begin set_config(32'd31, 32'd16, 32'd0, 32'd400);      step = 32'd60;   end
        5:  begin set_config(32'd8, 32'd5, 32'd600, 32'd200);      step = 32'd80;   end
        6:  begin
          set_config(32'd3, 32'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          step = 32'd500;
        end
        7:  begin set_config(32'd16, 32'd0, 32'd0, 32'd0);         step = 32'd10;   end
        8:  begin set_config(32'd2, 32'd1, 32'd150, 32'd30);       step = 32'd20;   end
        9:  begin
          set_config(32'd6, 32'd3, 32'h8000_0000, 32'h7FFF_FFFF);
          step = 32'h1000_0000;
        end
        10: begin
          set_config($urandom_range(0, 31), $urandom_range(0, 16),
                     $urandom_range(0, 3000), $urandom_range(0, 1500));
          step = 32'd200;
        end
        default: begin set_config(32'd12, 32'd8, 32'd400, 32'd150); step = 32'd50; end
      endcase
      for (int i = 0; i < POOL; i++)
        key_pool[i] = $urandom;

      // mostly requests over a small key set so hits, misses and evictions mix
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(0, 59) == 0)
          tick = $urandom;
        else if ($urandom_range(0, 3) != 0)
          tick = tick + $urandom_range(0, step);
        key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL - 1)];
        r = $urandom_range(0, 99);
        if (r < 72)
          queue_item(FN_REQUEST, key, 1'b1, tick);
        else if (r < 80)
          queue_item(FN_REQUEST, key, 1'b0, tick);
        else if (r < 94)
          queue_item(FN_SWEEP, key, $urandom_range(0, 1) == 1, tick);
        else if (r < 97)
          queue_item(FN_CLEAR, key, $urandom_range(0, 1) == 1, tick);
        else
          queue_item(FN_UNUSED, key, $urandom_range(0, 1) == 1, tick);
      end
      settle();
    end

    $display("Checked %0d results under %0d settings: %0d requests, %0d sweeps,",
             checked_count, setting_count, n_request, n_sweep);
    $display("%0d clears, %0d spare codes; %0d hits, %0d inserts, %0d full, %0d removed",
             n_clear, n_other, n_hit, n_insert, n_full, n_dropped);
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
